// ----- src/pcmffc_pkg.sv -----
package pcmffc_pkg;

	localparam int NUM_CH     = 8;
	localparam int SAMPLE_W   = 32;
	localparam int MAX_FACTOR = 16;
	localparam int ACC_W      = 35;
	localparam int DIV_STEPS  = ACC_W;
	localparam int DATA_W     = NUM_CH * SAMPLE_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);
	localparam int IDX_W      = $clog2(NUM_CH);
	localparam int FACTOR_W   = $clog2(MAX_FACTOR) + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAN,
		ST_ABS,
		ST_DIV,
		ST_FIX,
		ST_SEND
	} state_t;

	typedef enum logic [2:0] {
		REG_SRC_CHANNELS = 3'd0,
		REG_DST_MONO     = 3'd1,
		REG_SRC_BYTES    = 3'd2,
		REG_DST_BYTES    = 3'd3,
		REG_RATE_MODE    = 3'd4,
		REG_RATE_FACTOR  = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		RATE_PASS   = 2'd0,
		RATE_DECIM  = 2'd1,
		RATE_REPEAT = 2'd2
	} rate_mode_t;

	// Byte widths are clamped to 1..4 before they reach these functions.
	function automatic logic signed [SAMPLE_W-1:0] decode_sample(
		input logic [SAMPLE_W-1:0] raw,
		input logic [2:0]          nb
	);
		logic signed [SAMPLE_W-1:0] v;
		unique case (nb)
			3'd1: v = {{24{~raw[7]}}, ~raw[7], raw[6:0]};
			3'd2: v = {{16{raw[15]}}, raw[15:0]};
			3'd3: v = {{8{raw[23]}}, raw[23:0]};
			default: v = raw;
		endcase
		return v;
	endfunction

	function automatic logic [SAMPLE_W-1:0] encode_sample(
		input logic signed [SAMPLE_W-1:0] v,
		input logic [2:0]                 sb,
		input logic [2:0]                 db
	);
		logic [SAMPLE_W-1:0] s;
		logic [SAMPLE_W-1:0] u;
		logic [2:0]          up;
		logic [2:0]          dn;
		up = db - sb;
		dn = sb - db;
		if (db >= sb) begin
			s = v << {up[1:0], 3'b000};
		end else begin
			s = v >>> {dn[1:0], 3'b000};
		end
		unique case (db)
			3'd1: u = {24'd0, ~s[7], s[6:0]};
			3'd2: u = {16'd0, s[15:0]};
			3'd3: u = {8'd0, s[23:0]};
			default: u = s;
		endcase
		return u;
	endfunction

endpackage

// ----- src/pcm_frame_format_converter.sv -----
// Channel    | Direction | Signals
// -----------+-----------+-------------------------------------------------
// Input      | in        | s_axis_tvalid, s_axis_tready, s_axis_tdata
// Output     | out       | m_axis_tvalid, m_axis_tready, m_axis_tdata, m_axis_tlast
// Config     | in        | cfg_we, cfg_addr, cfg_wdata
//
// A frame is accepted in ST_IDLE, then ST_CHAN handles its channels one by one.
// Mono then adds a magnitude step, a 35-step restoring divider and a sign fix.
// Output transactions then follow in ST_SEND, each held while the sink stalls.
// Reset is asynchronous and restores the register defaults and decimation phase.
// Input is not accepted until the last output transaction of a frame is taken.
module pcm_frame_format_converter
	import pcmffc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,   // sample_0 .. sample_7, 32 bits each
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,   // out_0 .. out_7, 32 bits each
	output logic              m_axis_tlast,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_addr,
	input  logic [4:0]        cfg_wdata
);

	state_t state_q, state_d;

	logic [3:0]          src_channels_q;
	logic                dst_mono_q;
	logic [2:0]          src_bytes_q;
	logic [2:0]          dst_bytes_q;
	logic [1:0]          rate_mode_q;
	logic [4:0]          rate_factor_q;
	logic [3:0]          phase_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [FACTOR_W-1:0] rep_q;

	logic [SAMPLE_W-1:0]     samp_q [NUM_CH];
	logic [SAMPLE_W-1:0]     frame_q [NUM_CH];
	logic signed [ACC_W-1:0] acc_q;
	logic [3:0]              rem_q;
	logic                    neg_q;

	logic [IDX_W-1:0]    ch_m1;
	logic [3:0]          ch;
	logic [2:0]          sb;
	logic [2:0]          db;
	logic [FACTOR_W-1:0] f;
	logic [FACTOR_W-1:0] copies;
	logic                accept;
	logic                chan_last;
	logic signed [SAMPLE_W-1:0] dec;
	logic [4:0]          div_try;
	logic                div_ge;
	logic [4:0]          div_sub;
	logic signed [SAMPLE_W-1:0] mono_v;

	always_comb begin
		if (src_channels_q == 4'd0) begin
			ch_m1 = '0;
		end else if (src_channels_q > 4'(NUM_CH)) begin
			ch_m1 = IDX_W'(NUM_CH - 1);
		end else begin
			ch_m1 = IDX_W'(src_channels_q - 4'd1);
		end
		ch = {1'b0, ch_m1} + 4'd1;
		sb = (src_bytes_q == 3'd0) ? 3'd1 : (src_bytes_q > 3'd4) ? 3'd4 : src_bytes_q;
		db = (dst_bytes_q == 3'd0) ? 3'd1 : (dst_bytes_q > 3'd4) ? 3'd4 : dst_bytes_q;
		if (rate_factor_q == 5'd0) begin
			f = FACTOR_W'(1);
		end else if (rate_factor_q > 5'(MAX_FACTOR)) begin
			f = FACTOR_W'(MAX_FACTOR);
		end else begin
			f = FACTOR_W'(rate_factor_q);
		end
		unique case (rate_mode_q)
			RATE_DECIM:  copies = (phase_q == 4'd0) ? FACTOR_W'(1) : '0;
			RATE_REPEAT: copies = f;
			default:     copies = FACTOR_W'(1);
		endcase
	end

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign chan_last = (cnt_q[IDX_W-1:0] == ch_m1);
	assign dec       = decode_sample(samp_q[cnt_q[IDX_W-1:0]], sb);
	assign div_try   = {rem_q, acc_q[ACC_W-1]};
	assign div_ge    = (div_try >= {1'b0, ch});
	assign div_sub   = div_try - {1'b0, ch};
	assign mono_v    = neg_q ? -$signed(acc_q[SAMPLE_W-1:0]) : $signed(acc_q[SAMPLE_W-1:0]);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_axis_tvalid) state_d = ST_CHAN;
			ST_CHAN: begin
				if (chan_last) begin
					if (dst_mono_q) begin
						state_d = ST_ABS;
					end else begin
						state_d = (rep_q != '0) ? ST_SEND : ST_IDLE;
					end
				end
			end
			ST_ABS: state_d = ST_DIV;
			ST_DIV: if (cnt_q == '0) state_d = ST_FIX;
			ST_FIX: state_d = (rep_q != '0) ? ST_SEND : ST_IDLE;
			ST_SEND: if (m_axis_tready && rep_q == FACTOR_W'(1)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		m_axis_tvalid = (state_q == ST_SEND);
		m_axis_tlast  = (rep_q == FACTOR_W'(1));
		for (int i = 0; i < NUM_CH; i++) begin
			m_axis_tdata[i*SAMPLE_W +: SAMPLE_W] = frame_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			src_channels_q <= 4'd2;
			dst_mono_q     <= 1'b0;
			src_bytes_q    <= 3'd2;
			dst_bytes_q    <= 3'd2;
			rate_mode_q    <= RATE_PASS;
			rate_factor_q  <= 5'd1;
			phase_q        <= 4'd0;
			cnt_q          <= '0;
			rep_q          <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_SRC_CHANNELS: src_channels_q <= cfg_wdata[3:0];
					REG_DST_MONO:     dst_mono_q     <= cfg_wdata[0];
					REG_SRC_BYTES:    src_bytes_q    <= cfg_wdata[2:0];
					REG_DST_BYTES:    dst_bytes_q    <= cfg_wdata[2:0];
					REG_RATE_MODE:    rate_mode_q    <= cfg_wdata[1:0];
					REG_RATE_FACTOR:  rate_factor_q  <= cfg_wdata;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						rep_q <= copies;
						if (rate_mode_q == RATE_DECIM) begin
							phase_q <= ({1'b0, phase_q} + 5'd1 >= f) ? 4'd0 : phase_q + 4'd1;
						end
					end
				end
				ST_CHAN: if (!chan_last) cnt_q <= cnt_q + CNT_W'(1);
				ST_ABS:  cnt_q <= CNT_W'(DIV_STEPS - 1);
				ST_DIV:  if (cnt_q != '0) cnt_q <= cnt_q - CNT_W'(1);
				ST_SEND: if (m_axis_tready) rep_q <= rep_q - FACTOR_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					for (int i = 0; i < NUM_CH; i++) begin
						samp_q[i]  <= s_axis_tdata[i*SAMPLE_W +: SAMPLE_W];
						frame_q[i] <= '0;
					end
					acc_q <= '0;
				end
			end
			ST_CHAN: begin
				if (dst_mono_q) begin
					acc_q <= acc_q + ACC_W'(dec);
				end else begin
					frame_q[cnt_q[IDX_W-1:0]] <= encode_sample(dec, sb, db);
				end
			end
			ST_ABS: begin
				neg_q <= acc_q[ACC_W-1];
				acc_q <= acc_q[ACC_W-1] ? -acc_q : acc_q;
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= div_ge ? div_sub[3:0] : div_try[3:0];
				acc_q <= {acc_q[ACC_W-2:0], div_ge};
			end
			ST_FIX: frame_q[0] <= encode_sample(mono_v, sb, db);
			default: ;
		endcase
	end

endmodule
